/* src/olpf_pkg.sv */
// Shared types, constants and tables for the odometry and landmark pose fusion block.
package olpf_pkg;

    // CORDIC iteration count; the arctangent table covers at most TABLE_LEN steps.
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int CNT_W        = $clog2(TABLE_LEN);

    // Internal datapath widths: wide vectors for CORDIC growth, angle accumulator.
    localparam int DW   = 40;
    localparam int ZW   = 34;
    localparam int MBW  = 25;
    localparam int PW   = DW + MBW;

    // Rotation gain, Q24.
    localparam logic signed [MBW-1:0] GAIN_Q24 = 25'sd10188014;

    // Arctangent table, 32 bit binary angles.
    localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Configuration register indexes.
    localparam logic [2:0] REG_ODOM_WEIGHT = 3'd0;
    localparam logic [2:0] REG_LANDMARK_X  = 3'd1;
    localparam logic [2:0] REG_LANDMARK_Y  = 3'd2;
    localparam logic [2:0] REG_REF_X       = 3'd3;
    localparam logic [2:0] REG_REF_Y       = 3'd4;
    localparam logic [2:0] REG_REF_HEADING = 3'd5;

    typedef enum logic {
        CM_ROT,
        CM_VEC
    } cmode_t;

    // Datapath commands issued by the controller.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ROT1,
        OP_GX,
        OP_GY,
        OP_GD,
        OP_MXA,
        OP_MXB,
        OP_MXC,
        OP_MYA,
        OP_MYB,
        OP_MYC,
        OP_ROT2,
        OP_VEC1,
        OP_BOD,
        OP_VEC2,
        OP_BOB,
        OP_MBA,
        OP_MBB,
        OP_MBC,
        OP_VEC3,
        OP_FIN
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROT1,
        ST_ROT1_W,
        ST_G1X,
        ST_G1Y,
        ST_G1D,
        ST_MXA,
        ST_MXB,
        ST_MXC,
        ST_MYA,
        ST_MYB,
        ST_MYC,
        ST_ROT2,
        ST_ROT2_W,
        ST_G2X,
        ST_G2Y,
        ST_G2D,
        ST_VEC1,
        ST_VEC1_W,
        ST_BOD,
        ST_VEC2,
        ST_VEC2_W,
        ST_BOB,
        ST_MBA,
        ST_MBB,
        ST_MBC,
        ST_VEC3,
        ST_VEC3_W,
        ST_FIN
    } state_t;

    // Status returned from the datapath to the controller.
    typedef struct packed {
        logic cordic_done;
        logic out_busy;
    } sts_t;

endpackage

/* src/olpf_cordic.sv */
// Iterative CORDIC unit for rotation and vectoring, one step per cycle.
module olpf_cordic
    import olpf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cmode_t               mode,
    input  logic signed [DW-1:0] x_in,
    input  logic signed [DW-1:0] y_in,
    input  logic [15:0]          ang_in,
    output logic signed [DW-1:0] x_out,
    output logic signed [DW-1:0] y_out,
    output logic [15:0]          ang_out,
    output logic                 done
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    cmode_t               mode_reg;
    logic                 zero_reg;
    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    logic                 flip;
    logic [15:0]          a16;
    logic signed [DW-1:0] dx, dy;
    logic signed [ZW-1:0] atan_z;
    logic [31:0]          z_round;

    // Start values, including the half turn pre-rotation.
    always_comb
    begin
        flip = ang_in[15] ^ ang_in[14];
        a16  = flip ? {~ang_in[15], ang_in[14:0]} : ang_in;
    end

    // One micro-rotation.
    always_comb
    begin
        dx     = y_reg >>> cnt_reg;
        dy     = x_reg >>> cnt_reg;
        atan_z = {{(ZW - 32){1'b0}}, ATAN_TAB[cnt_reg]};
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        unique case (mode_reg)
            CM_ROT:
            begin
                if (!z_reg[ZW-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_z;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_z;
                end
            end
            CM_VEC:
            begin
                if (!y_reg[DW-1] && (y_reg != '0))
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_z;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_z;
                end
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Vector registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= mode;
            zero_reg <= (x_in == '0) && (y_in == '0);
            if (mode == CM_ROT)
            begin
                x_reg <= flip ? -x_in : x_in;
                y_reg <= flip ? -y_in : y_in;
                z_reg <= {{(ZW - 32){a16[15]}}, a16, 16'h0000};
            end
            else
            begin
                x_reg <= x_in[DW-1] ? -x_in : x_in;
                y_reg <= x_in[DW-1] ? -y_in : y_in;
                z_reg <= x_in[DW-1] ? ZW'(34'h080000000) : '0;
            end
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign z_round = z_reg[31:0] + 32'h00008000;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign ang_out = zero_reg ? 16'h0000 : z_round[31:16];
    assign done    = done_reg;

endmodule

/* src/olpf_datapath.sv */
// Datapath: configuration registers, shared multiplier, CORDIC unit and result register.
module olpf_datapath
    import olpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  op_t                op,
    output sts_t               sts,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] odom_x,
    input  logic signed [31:0] odom_y,
    input  logic signed [15:0] odom_heading,
    input  logic               obs_valid,
    input  logic signed [31:0] obs_dx,
    input  logic signed [31:0] obs_dy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pose_x,
    output logic signed [31:0] pose_y,
    output logic signed [15:0] pose_heading
);

    // Configuration registers.
    logic [16:0]        odom_weight_reg;
    logic signed [31:0] landmark_x_reg, landmark_y_reg, ref_x_reg, ref_y_reg;
    logic [15:0]        ref_heading_reg;

    // Working registers.
    logic [15:0]          lh_reg;
    logic signed [31:0]   px_reg, py_reg, fx_reg, fy_reg;
    logic [15:0]          ph_reg, bod_reg, bob_reg, bmix_reg;
    logic                 obs_reg;
    logic signed [31:0]   dx_reg, dy_reg;
    logic signed [DW-1:0] gx_reg, gy_reg;
    logic signed [PW-1:0] prod_reg, acc_reg;
    logic                 out_valid_reg;
    logic signed [31:0]   pose_x_reg, pose_y_reg;
    logic [15:0]          pose_h_reg;

    logic [16:0]          w_eff, w_lid;
    logic signed [MBW-1:0] w_op, wl_op;
    logic signed [DW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] g_sum;
    logic signed [DW-1:0] g_val;
    logic signed [PW:0]   m_sum;
    logic signed [31:0]   m_sat;
    logic signed [32:0]   dpx, dpy;
    logic signed [DW-1:0] lx_w, ly_w;

    logic                 c_start;
    cmode_t               c_mode;
    logic signed [DW-1:0] c_x, c_y, c_xo, c_yo;
    logic [15:0]          c_ang, c_ango;
    logic                 c_done;

    // Weight clipping and operand extension.
    always_comb
    begin
        w_eff = odom_weight_reg[16] ? 17'h10000 : odom_weight_reg;
        w_lid = 17'h10000 - w_eff;
        w_op  = MBW'(w_eff);
        wl_op = MBW'(w_lid);
        lx_w  = DW'(landmark_x_reg);
        ly_w  = DW'(landmark_y_reg);
        dpx   = 33'(odom_x) - 33'(ref_x_reg);
        dpy   = 33'(odom_y) - 33'(ref_y_reg);
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op)
            OP_GX:   begin mul_a = c_xo;              mul_b = GAIN_Q24; end
            OP_GY:   begin mul_a = c_yo;              mul_b = GAIN_Q24; end
            OP_MXA:  begin mul_a = DW'(px_reg);       mul_b = w_op;     end
            OP_MXB:  begin mul_a = lx_w - gx_reg;     mul_b = wl_op;    end
            OP_MYA:  begin mul_a = DW'(py_reg);       mul_b = w_op;     end
            OP_MYB:  begin mul_a = ly_w - gy_reg;     mul_b = wl_op;    end
            OP_MBA:  begin mul_a = DW'($signed(bod_reg)); mul_b = w_op;  end
            OP_MBB:  begin mul_a = DW'($signed(bob_reg)); mul_b = wl_op; end
            default: begin mul_a = '0;                mul_b = '0;       end
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    // Gain rounding and weighted mix with saturation.
    always_comb
    begin
        g_sum = prod_reg + PW'(65'sd8388608);
        g_val = g_sum[DW+23:24];
        m_sum = (PW + 1)'(acc_reg) + (PW + 1)'(prod_reg) + (PW + 1)'(66'sd32768);
        if ((m_sum[PW:47] == '0) || (m_sum[PW:47] == '1))
        begin
            m_sat = m_sum[47:16];
        end
        else
        begin
            m_sat = m_sum[PW] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
    end

    // CORDIC command selection.
    always_comb
    begin
        c_start = 1'b0;
        c_mode  = CM_VEC;
        c_x     = '0;
        c_y     = '0;
        c_ang   = 16'h0000;
        unique case (op)
            OP_ROT1:
            begin
                c_start = 1'b1;
                c_mode  = CM_ROT;
                c_x     = DW'(dx_reg);
                c_y     = DW'(dy_reg);
                c_ang   = 16'h0000 - lh_reg;
            end
            OP_ROT2:
            begin
                c_start = 1'b1;
                c_mode  = CM_ROT;
                c_x     = lx_w - DW'(px_reg);
                c_y     = ly_w - DW'(py_reg);
                c_ang   = ph_reg;
            end
            OP_VEC1:
            begin
                c_start = 1'b1;
                c_x     = gx_reg;
                c_y     = gy_reg;
            end
            OP_VEC2:
            begin
                c_start = 1'b1;
                c_x     = DW'(dx_reg);
                c_y     = DW'(dy_reg);
            end
            OP_VEC3:
            begin
                c_start = 1'b1;
                c_x     = lx_w - DW'(fx_reg);
                c_y     = ly_w - DW'(fy_reg);
            end
            default:
            begin
                c_start = 1'b0;
            end
        endcase
    end

    olpf_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (c_start),
        .mode    (c_mode),
        .x_in    (c_x),
        .y_in    (c_y),
        .ang_in  (c_ang),
        .x_out   (c_xo),
        .y_out   (c_yo),
        .ang_out (c_ango),
        .done    (c_done)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odom_weight_reg <= 17'd32768;
            landmark_x_reg  <= '0;
            landmark_y_reg  <= '0;
            ref_x_reg       <= '0;
            ref_y_reg       <= '0;
            ref_heading_reg <= '0;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                REG_ODOM_WEIGHT: odom_weight_reg <= cfg_data[16:0];
                REG_LANDMARK_X:  landmark_x_reg  <= cfg_data;
                REG_LANDMARK_Y:  landmark_y_reg  <= cfg_data;
                REG_REF_X:       ref_x_reg       <= cfg_data;
                REG_REF_Y:       ref_y_reg       <= cfg_data;
                REG_REF_HEADING: ref_heading_reg <= cfg_data[15:0];
                default:         odom_weight_reg <= odom_weight_reg;
            endcase
        end
    end

    // Working registers, stepped by the controller's commands.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        unique case (op)
            OP_LOAD:
            begin
                px_reg  <= (dpx[32] != dpx[31]) ? (dpx[32] ? 32'sh80000000 : 32'sh7FFFFFFF)
                                                : dpx[31:0];
                py_reg  <= (dpy[32] != dpy[31]) ? (dpy[32] ? 32'sh80000000 : 32'sh7FFFFFFF)
                                                : dpy[31:0];
                ph_reg  <= odom_heading - ref_heading_reg;
                obs_reg <= obs_valid;
                dx_reg  <= obs_dx;
                dy_reg  <= obs_dy;
            end
            OP_GY:   gx_reg   <= g_val;
            OP_GD:   gy_reg   <= g_val;
            OP_MXB:  acc_reg  <= prod_reg;
            OP_MXC:  fx_reg   <= m_sat;
            OP_MYB:  acc_reg  <= prod_reg;
            OP_MYC:  fy_reg   <= m_sat;
            OP_BOD:  bod_reg  <= c_ango;
            OP_BOB:  bob_reg  <= c_ango;
            OP_MBB:  acc_reg  <= prod_reg;
            OP_MBC:  bmix_reg <= m_sum[31:16];
            OP_FIN:
            begin
                pose_x_reg <= obs_reg ? fx_reg : px_reg;
                pose_y_reg <= obs_reg ? fy_reg : py_reg;
                pose_h_reg <= obs_reg ? (c_ango - bmix_reg) : ph_reg;
            end
            default: acc_reg <= acc_reg;
        endcase
    end

    // Kept heading and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lh_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == OP_FIN)
            begin
                lh_reg        <= obs_reg ? (c_ango - bmix_reg) : ph_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.cordic_done = c_done;
    assign sts.out_busy    = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign pose_x          = pose_x_reg;
    assign pose_y          = pose_y_reg;
    assign pose_heading    = pose_h_reg;

endmodule

/* src/olpf_ctrl.sv */
// Controller state machine that sequences the fusion datapath.
module olpf_ctrl
    import olpf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic obs_valid,
    output logic in_stall,
    input  sts_t sts,
    output op_t  op
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = obs_valid ? ST_ROT1 : ST_FIN;
                end
            end
            ST_ROT1:   state_next = ST_ROT1_W;
            ST_ROT1_W: if (sts.cordic_done) state_next = ST_G1X;
            ST_G1X:    state_next = ST_G1Y;
            ST_G1Y:    state_next = ST_G1D;
            ST_G1D:    state_next = ST_MXA;
            ST_MXA:    state_next = ST_MXB;
            ST_MXB:    state_next = ST_MXC;
            ST_MXC:    state_next = ST_MYA;
            ST_MYA:    state_next = ST_MYB;
            ST_MYB:    state_next = ST_MYC;
            ST_MYC:    state_next = ST_ROT2;
            ST_ROT2:   state_next = ST_ROT2_W;
            ST_ROT2_W: if (sts.cordic_done) state_next = ST_G2X;
            ST_G2X:    state_next = ST_G2Y;
            ST_G2Y:    state_next = ST_G2D;
            ST_G2D:    state_next = ST_VEC1;
            ST_VEC1:   state_next = ST_VEC1_W;
            ST_VEC1_W: if (sts.cordic_done) state_next = ST_BOD;
            ST_BOD:    state_next = ST_VEC2;
            ST_VEC2:   state_next = ST_VEC2_W;
            ST_VEC2_W: if (sts.cordic_done) state_next = ST_BOB;
            ST_BOB:    state_next = ST_MBA;
            ST_MBA:    state_next = ST_MBB;
            ST_MBB:    state_next = ST_MBC;
            ST_MBC:    state_next = ST_VEC3;
            ST_VEC3:   state_next = ST_VEC3_W;
            ST_VEC3_W: if (sts.cordic_done) state_next = ST_FIN;
            ST_FIN:    if (!sts.out_busy) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        op       = OP_NOP;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                op       = in_valid ? OP_LOAD : OP_NOP;
            end
            ST_ROT1: op = OP_ROT1;
            ST_G1X:  op = OP_GX;
            ST_G1Y:  op = OP_GY;
            ST_G1D:  op = OP_GD;
            ST_MXA:  op = OP_MXA;
            ST_MXB:  op = OP_MXB;
            ST_MXC:  op = OP_MXC;
            ST_MYA:  op = OP_MYA;
            ST_MYB:  op = OP_MYB;
            ST_MYC:  op = OP_MYC;
            ST_ROT2: op = OP_ROT2;
            ST_G2X:  op = OP_GX;
            ST_G2Y:  op = OP_GY;
            ST_G2D:  op = OP_GD;
            ST_VEC1: op = OP_VEC1;
            ST_BOD:  op = OP_BOD;
            ST_VEC2: op = OP_VEC2;
            ST_BOB:  op = OP_BOB;
            ST_MBA:  op = OP_MBA;
            ST_MBB:  op = OP_MBB;
            ST_MBC:  op = OP_MBC;
            ST_VEC3: op = OP_VEC3;
            ST_FIN:  op = sts.out_busy ? OP_NOP : OP_FIN;
            default: op = OP_NOP;
        endcase
    end

    // A transaction is only taken while the sequencer is idle.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (state_reg == ST_IDLE))
        else $error("input taken while the sequencer is busy");

    // A free result register always lets the result out and returns to idle.
    a_fin_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && !sts.out_busy) |=> (state_reg == ST_IDLE))
        else $error("result not issued from the final state");

    // A finished CORDIC run moves the sequencer on from the wait state.
    a_wait_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ROT1_W || state_reg == ST_VEC3_W) && sts.cordic_done)
        |=> (state_reg != $past(state_reg)))
        else $error("CORDIC completion missed");

endmodule

/* src/odometry_landmark_pose_fusion.sv */
// Top level of the odometry and landmark pose fusion block.
//
// Input channel: in_valid / in_stall carries one odometry pose with an
// optional landmark observation per transaction. Output channel:
// out_valid / out_stall carries one fused pose per input transaction.
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (0 weight, 1-2 landmark, 3-5 reference pose); unknown indexes
// are ignored. Write only while the block is idle.
// Sequencing: an item without an observation goes straight to the final
// state, which registers the result. With an observation the sequencer
// runs five CORDIC passes of 16 iterations each on one shared CORDIC
// unit plus gain and mixing steps on one shared multiplier before the
// final state. The next item is taken only once the sequencer is back
// in idle, so items are worked on one at a time.
// Reset clears the sequencer, the kept heading and the output valid, and
// loads the registers with their defaults (weight one half).
// When the receiver stalls, the result is held in the output register;
// a following item may be accepted and worked on, but its result waits
// until the held transaction has been taken.
module odometry_landmark_pose_fusion
    import olpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] odom_x,
    input  logic signed [31:0] odom_y,
    input  logic signed [15:0] odom_heading,
    input  logic               obs_valid,
    input  logic signed [31:0] obs_dx,
    input  logic signed [31:0] obs_dy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pose_x,
    output logic signed [31:0] pose_y,
    output logic signed [15:0] pose_heading
);

    op_t  op;
    sts_t sts;

    olpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .obs_valid (obs_valid),
        .in_stall  (in_stall),
        .sts       (sts),
        .op        (op)
    );

    olpf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .odom_x       (odom_x),
        .odom_y       (odom_y),
        .odom_heading (odom_heading),
        .obs_valid    (obs_valid),
        .obs_dx       (obs_dx),
        .obs_dy       (obs_dy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading)
    );

endmodule
